/* rtl/ftg_pkg.sv */
// shared types, constants and microprogram for the fixed timestep tick generator
package ftg_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int TICK_BITS  = 48;
    localparam int TOTAL_BITS = 56;
    localparam int STEP_W     = 21;
    localparam int MAX_W      = 8;
    localparam int DELTA_W    = 25;
    localparam int LEFT_W     = 23;
    localparam int ALPHA_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = 21;
    localparam int PC_W       = 3;
    localparam int CNT_W      = 4;
    localparam int MOD_ITERS  = 7;
    localparam int SH_W       = STEP_W + MOD_ITERS - 1;

    localparam logic [STEP_W-1:0]  STEP_MIN   = STEP_W'((64'd1 << FRAC_BITS) / 240);
    localparam logic [STEP_W-1:0]  STEP_MAX   = STEP_W'((64'd1 << FRAC_BITS) / 15);
    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(279620);
    localparam logic [MAX_W-1:0]   MAX_RESET  = MAX_W'(5);
    localparam logic [LEFT_W-1:0]  DELTA_MAX  = LEFT_W'((64'd1 << FRAC_BITS) / 4);
    localparam logic [CNT_W-1:0]   MOD_LAST   = CNT_W'(MOD_ITERS - 1);
    localparam logic [CNT_W-1:0]   DIV_LAST   = CNT_W'(ALPHA_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS  = 1'b1;

    localparam logic [PC_W-1:0] PC_ACCEPT   = 3'd0;
    localparam logic [PC_W-1:0] PC_STEP     = 3'd1;
    localparam logic [PC_W-1:0] PC_MOD_INIT = 3'd2;
    localparam logic [PC_W-1:0] PC_MOD      = 3'd3;
    localparam logic [PC_W-1:0] PC_DIV_INIT = 3'd4;
    localparam logic [PC_W-1:0] PC_DIV      = 3'd5;
    localparam logic [PC_W-1:0] PC_EMIT     = 3'd6;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_STEP,
        OP_MOD_INIT,
        OP_MOD,
        OP_DIV_INIT,
        OP_DIV,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_STEP_OK,
        C_CNT_ZERO,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  tgt_true;
        logic [PC_W-1:0]  tgt_false;
    } t_uword;

    typedef struct packed {
        logic step_ok;
        logic cnt_zero;
    } t_dp_flags;

    typedef struct packed {
        logic in_valid;
        logic step_ok;
        logic cnt_zero;
        logic out_free;
    } t_status;

    function automatic t_uword micro_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            PC_ACCEPT:   w = '{OP_ACCEPT,   C_IN_VALID, PC_STEP,     PC_ACCEPT};
            PC_STEP:     w = '{OP_STEP,     C_STEP_OK,  PC_STEP,     PC_MOD_INIT};
            PC_MOD_INIT: w = '{OP_MOD_INIT, C_ALWAYS,   PC_MOD,      PC_MOD};
            PC_MOD:      w = '{OP_MOD,      C_CNT_ZERO, PC_DIV_INIT, PC_MOD};
            PC_DIV_INIT: w = '{OP_DIV_INIT, C_ALWAYS,   PC_DIV,      PC_DIV};
            PC_DIV:      w = '{OP_DIV,      C_CNT_ZERO, PC_EMIT,     PC_DIV};
            PC_EMIT:     w = '{OP_EMIT,     C_OUT_FREE, PC_ACCEPT,   PC_EMIT};
            default:     w = '{OP_NOP,      C_ALWAYS,   PC_ACCEPT,   PC_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

/* rtl/ftg_seq.sv */
// microcode sequencer: step counter, control rom and conditional jumps
module ftg_seq
    import ftg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_op     o_op
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w_word;
    logic            w_take;

    assign w_word = micro_rom(r_pc);
    assign o_op   = w_word.op;

    always_comb begin
        unique case (w_word.cond)
            C_ALWAYS:   w_take = 1'b1;
            C_IN_VALID: w_take = i_status.in_valid;
            C_STEP_OK:  w_take = i_status.step_ok;
            C_CNT_ZERO: w_take = i_status.cnt_zero;
            C_OUT_FREE: w_take = i_status.out_free;
            default:    w_take = 1'b1;
        endcase
        n_pc = w_take ? w_word.tgt_true : w_word.tgt_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_ACCEPT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

/* rtl/ftg_dp.sv */
// datapath: accumulator, totals, step loop, modulo and alpha divider
module ftg_dp
    import ftg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_op                      i_op,
    input  logic                     i_in_valid,
    input  logic                     i_action,
    input  logic signed [DELTA_W-1:0] i_frame_delta,
    input  logic [STEP_W-1:0]        i_step,
    input  logic [MAX_W-1:0]         i_max_steps,
    output t_dp_flags                o_flags,
    output logic [MAX_W-1:0]         o_steps,
    output logic [ALPHA_W-1:0]       o_alpha,
    output logic [TOTAL_BITS-1:0]    o_total,
    output logic [TICK_BITS-1:0]     o_tick,
    output logic                     o_dropped
);

    logic [LEFT_W-1:0]     r_left;
    logic [TOTAL_BITS-1:0] r_total;
    logic [TICK_BITS-1:0]  r_tick;
    logic [MAX_W-1:0]      r_steps;
    logic                  r_dropped;
    logic [CNT_W-1:0]      r_cnt;
    logic [STEP_W-1:0]     r_rem;
    logic [ALPHA_W-1:0]    r_quo;

    logic [LEFT_W-1:0]     w_delta;
    logic                  w_left_ge;
    logic                  w_step_ok;
    logic                  w_accept;
    logic [SH_W-1:0]       w_step_sh;
    logic                  w_mod_ge;
    logic [STEP_W:0]       w_rem2;
    logic                  w_div_ge;

    always_comb begin
        if (i_frame_delta[DELTA_W-1]) begin
            w_delta = '0;
        end else if (i_frame_delta[DELTA_W-2:0] > (DELTA_W-1)'(DELTA_MAX)) begin
            w_delta = DELTA_MAX;
        end else begin
            w_delta = i_frame_delta[LEFT_W-1:0];
        end
    end

    assign w_accept  = (i_op == OP_ACCEPT) && i_in_valid;
    assign w_left_ge = r_left >= LEFT_W'(i_step);
    assign w_step_ok = w_left_ge && (r_steps < i_max_steps);
    assign w_step_sh = SH_W'(i_step) << r_cnt;
    assign w_mod_ge  = SH_W'(r_left) >= w_step_sh;
    assign w_rem2    = {r_rem, 1'b0};
    assign w_div_ge  = w_rem2 >= {1'b0, i_step};

    assign o_flags.step_ok  = w_step_ok;
    assign o_flags.cnt_zero = (r_cnt == '0);
    assign o_steps          = r_steps;
    assign o_alpha          = r_quo;
    assign o_total          = r_total;
    assign o_tick           = r_tick;
    assign o_dropped        = r_dropped;

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_total <= '0;
            r_tick  <= '0;
        end else begin
            case (i_op)
                OP_ACCEPT: begin
                    if (i_in_valid) begin
                        if (i_action) begin
                            r_left  <= '0;
                            r_total <= '0;
                            r_tick  <= '0;
                        end else begin
                            r_left <= r_left + w_delta;
                        end
                    end
                end
                OP_STEP: begin
                    if (w_step_ok) begin
                        r_left  <= r_left - LEFT_W'(i_step);
                        r_total <= r_total + TOTAL_BITS'(i_step);
                        r_tick  <= r_tick + TICK_BITS'(1);
                    end
                end
                OP_MOD: begin
                    if (w_mod_ge) begin
                        r_left <= LEFT_W'(SH_W'(r_left) - w_step_sh);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // per item working registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_ACCEPT: begin
                if (w_accept) begin
                    r_steps   <= '0;
                    r_dropped <= 1'b0;
                end
            end
            OP_STEP: begin
                if (w_step_ok) begin
                    r_steps <= r_steps + MAX_W'(1);
                end
            end
            OP_MOD_INIT: begin
                r_dropped <= w_left_ge;
                r_cnt     <= MOD_LAST;
            end
            OP_MOD: begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            OP_DIV_INIT: begin
                r_rem <= r_left[STEP_W-1:0];
                r_quo <= '0;
                r_cnt <= DIV_LAST;
            end
            OP_DIV: begin
                if (w_div_ge) begin
                    r_rem <= STEP_W'(w_rem2 - {1'b0, i_step});
                end else begin
                    r_rem <= w_rem2[STEP_W-1:0];
                end
                r_quo <= {r_quo[ALPHA_W-2:0], w_div_ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    a_mod_leaves_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_DIV_INIT) |-> (r_left < LEFT_W'(i_step)))
        else $error("accumulator not below one step after modulo");

    a_steps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_STEP) |-> (r_steps <= i_max_steps))
        else $error("step count above limit");

    a_clear_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action) |=> (r_left == '0 && r_total == '0 && r_tick == '0))
        else $error("clear request left state behind");

endmodule

/* rtl/fixed_timestep_tick_generator.sv */
// top level: configuration registers, sequencer, datapath and output register
//
//  channel | direction | handshake                 | fields
//  in      | input     | i_in_valid / o_in_stall   | i_action, i_frame_delta
//  out     | output    | o_out_valid / i_out_stall | steps, step length, alpha, totals, flag
//  cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// a request passes from acceptance through one step state per step and one exit step, the
// modulo init and iterations, the divider init and iterations, and the emit step that loads it
// the input is free again the cycle after the result loads; the next request is taken even
// while the previous result is still stalled
// a stalled result holds the sequencer at its emit step until the output register frees
// synchronous active-low reset clears totals and accumulator and restores configuration
module fixed_timestep_tick_generator
    import ftg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_action,
    input  logic signed [DELTA_W-1:0] i_frame_delta,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [MAX_W-1:0]          o_steps_taken,
    output logic [STEP_W-1:0]         o_step_length,
    output logic [ALPHA_W-1:0]        o_blend_alpha,
    output logic [TOTAL_BITS-1:0]     o_total_time,
    output logic [TICK_BITS-1:0]      o_tick_count,
    output logic                      o_time_dropped,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    logic [STEP_W-1:0]     r_fixed_step;
    logic [MAX_W-1:0]      r_max_steps;
    logic                  r_out_valid;
    logic [MAX_W-1:0]      r_steps_taken;
    logic [STEP_W-1:0]     r_step_length;
    logic [ALPHA_W-1:0]    r_blend_alpha;
    logic [TOTAL_BITS-1:0] r_total_time;
    logic [TICK_BITS-1:0]  r_tick_count;
    logic                  r_time_dropped;

    t_op                   w_op;
    t_status               w_status;
    t_dp_flags             w_flags;
    logic                  w_out_free;
    logic                  w_load;
    logic [STEP_W-1:0]     w_step_clamped;
    logic [MAX_W-1:0]      w_dp_steps;
    logic [ALPHA_W-1:0]    w_dp_alpha;
    logic [TOTAL_BITS-1:0] w_dp_total;
    logic [TICK_BITS-1:0]  w_dp_tick;
    logic                  w_dp_dropped;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (w_op == OP_EMIT) && w_out_free;
    assign o_in_stall = (w_op != OP_ACCEPT);

    assign w_status.in_valid = i_in_valid;
    assign w_status.step_ok  = w_flags.step_ok;
    assign w_status.cnt_zero = w_flags.cnt_zero;
    assign w_status.out_free = w_out_free;

    always_comb begin
        if (i_cfg_data[STEP_W-1:0] < STEP_MIN) begin
            w_step_clamped = STEP_MIN;
        end else if (i_cfg_data[STEP_W-1:0] > STEP_MAX) begin
            w_step_clamped = STEP_MAX;
        end else begin
            w_step_clamped = i_cfg_data[STEP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed_step <= STEP_RESET;
            r_max_steps  <= MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIXED_STEP: r_fixed_step <= w_step_clamped;
                CFG_MAX_STEPS: begin
                    if (i_cfg_data[MAX_W-1:0] == '0) begin
                        r_max_steps <= MAX_W'(1);
                    end else begin
                        r_max_steps <= i_cfg_data[MAX_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    ftg_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_op     (w_op)
    );

    ftg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .i_in_valid    (i_in_valid),
        .i_action      (i_action),
        .i_frame_delta (i_frame_delta),
        .i_step        (r_fixed_step),
        .i_max_steps   (r_max_steps),
        .o_flags       (w_flags),
        .o_steps       (w_dp_steps),
        .o_alpha       (w_dp_alpha),
        .o_total       (w_dp_total),
        .o_tick        (w_dp_tick),
        .o_dropped     (w_dp_dropped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_steps_taken  <= w_dp_steps;
            r_step_length  <= r_fixed_step;
            r_blend_alpha  <= w_dp_alpha;
            r_total_time   <= w_dp_total;
            r_tick_count   <= w_dp_tick;
            r_time_dropped <= w_dp_dropped;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_steps_taken  = r_steps_taken;
    assign o_step_length  = r_step_length;
    assign o_blend_alpha  = r_blend_alpha;
    assign o_total_time   = r_total_time;
    assign o_tick_count   = r_tick_count;
    assign o_time_dropped = r_time_dropped;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_load)
        else $error("stalled result overwritten");

    a_busy_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && i_in_valid) |=> o_in_stall)
        else $error("second request taken while one is in progress");

endmodule

/* tb/testbench.sv */
// self-checking testbench for the fixed timestep tick generator: frame table, then random frames
module testbench;
    import ftg_pkg::*;

    localparam logic ACT_ADVANCE = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    localparam int N_PLAN       = 18;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 180;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 300;
    localparam int PRINT_LIMIT  = 100;

    localparam logic [STEP_W-1:0] ONE_STEP = STEP_RESET;

    typedef struct packed {
        logic [MAX_W-1:0]      steps;
        logic [STEP_W-1:0]     step_len;
        logic [ALPHA_W-1:0]    alpha;
        logic [TOTAL_BITS-1:0] total;
        logic [TICK_BITS-1:0]  ticks;
        logic                  dropped;
    } t_frame_result;

    typedef struct packed {
        logic                action;
        logic [DELTA_W-1:0]  delta;
        logic                pinned;
        t_frame_result       res;
    } t_frame_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic                      i_action = 1'b0;
    logic signed [DELTA_W-1:0] i_frame_delta = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [MAX_W-1:0]          o_steps_taken;
    logic [STEP_W-1:0]         o_step_length;
    logic [ALPHA_W-1:0]        o_blend_alpha;
    logic [TOTAL_BITS-1:0]     o_total_time;
    logic [TICK_BITS-1:0]      o_tick_count;
    logic                      o_time_dropped;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_W-1:0]          i_cfg_data = '0;

    fixed_timestep_tick_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_frame_delta  (i_frame_delta),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_steps_taken  (o_steps_taken),
        .o_step_length  (o_step_length),
        .o_blend_alpha  (o_blend_alpha),
        .o_total_time   (o_total_time),
        .o_tick_count   (o_tick_count),
        .o_time_dropped (o_time_dropped),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // timebase model state
    logic [63:0]           m_left;
    logic [TOTAL_BITS-1:0] m_total;
    logic [TICK_BITS-1:0]  m_ticks;
    logic [STEP_W-1:0]     m_step;
    logic [MAX_W-1:0]      m_max;

    t_frame_result tick_results_q[$];
    t_frame_row    frame_rows_q[$];
    int            mismatches = 0;
    int            idle_cycles = 0;
    int            burst_left = 0;
    bit            hold_req = 1'b0;

    t_frame_row frame_plan [N_PLAN] = '{
        '{ACT_CLEAR,   25'h0AAAAAA, 1'b1, '{8'd0, ONE_STEP, 16'd0, 56'd0, 48'd0, 1'b0}},
        '{ACT_ADVANCE, 25'h0000000, 1'b1, '{8'd0, ONE_STEP, 16'd0, 56'd0, 48'd0, 1'b0}},
        '{ACT_ADVANCE, 25'h1000000, 1'b1, '{8'd0, ONE_STEP, 16'd0, 56'd0, 48'd0, 1'b0}},
        '{ACT_ADVANCE, 25'h1FFFFFF, 1'b1, '{8'd0, ONE_STEP, 16'd0, 56'd0, 48'd0, 1'b0}},
        '{ACT_ADVANCE, 25'd279620,  1'b1, '{8'd1, ONE_STEP, 16'd0, 56'd279620, 48'd1, 1'b0}},
        '{ACT_ADVANCE, 25'd279619,  1'b1, '{8'd0, ONE_STEP, 16'd65535, 56'd279620, 48'd1, 1'b0}},
        '{ACT_ADVANCE, 25'd1,       1'b1, '{8'd1, ONE_STEP, 16'd0, 56'd559240, 48'd2, 1'b0}},
        '{ACT_ADVANCE, 25'h0FFFFFF, 1'b0, '0},
        '{ACT_CLEAR,   25'h1FFFFFF, 1'b1, '{8'd0, ONE_STEP, 16'd0, 56'd0, 48'd0, 1'b0}},
        '{ACT_ADVANCE, 25'd4194304, 1'b0, '0},
        '{ACT_ADVANCE, 25'd4194305, 1'b0, '0},
        '{ACT_ADVANCE, 25'h0800000, 1'b0, '0},
        '{ACT_ADVANCE, 25'h1555555, 1'b0, '0},
        '{ACT_ADVANCE, 25'h0AAAAAA, 1'b0, '0},
        '{ACT_ADVANCE, 25'd1398100, 1'b0, '0},
        '{ACT_ADVANCE, 25'd1398101, 1'b0, '0},
        '{ACT_ADVANCE, 25'd1677720, 1'b0, '0},
        '{ACT_CLEAR,   25'h0000000, 1'b1, '{8'd0, ONE_STEP, 16'd0, 56'd0, 48'd0, 1'b0}}
    };

    task automatic predict_frame(input logic action, input logic [DELTA_W-1:0] delta,
                                 output t_frame_result r);
        logic [63:0] add;
        logic [63:0] quot;
        int unsigned n;
        n = 0;
        r = '0;
        if (action == ACT_CLEAR) begin
            m_left  = '0;
            m_total = '0;
            m_ticks = '0;
        end else begin
            if (delta[DELTA_W-1])
                add = '0;
            else if (64'(delta) > 64'(DELTA_MAX))
                add = 64'(DELTA_MAX);
            else
                add = 64'(delta);
            m_left = m_left + add;
            while (m_left >= 64'(m_step) && n < m_max) begin
                m_left  = m_left - 64'(m_step);
                m_total = m_total + TOTAL_BITS'(m_step);
                m_ticks = m_ticks + 1'b1;
                n++;
            end
            if (m_left >= 64'(m_step)) begin
                m_left    = m_left % 64'(m_step);
                r.dropped = 1'b1;
            end
        end
        quot       = (m_left << 16) / 64'(m_step);
        r.alpha    = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
        r.steps    = n[MAX_W-1:0];
        r.step_len = m_step;
        r.total    = m_total;
        r.ticks    = m_ticks;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_frame_result want;
        t_frame_row    row;
        if (!i_rst_n) begin
            m_left  = '0;
            m_total = '0;
            m_ticks = '0;
            m_step  = STEP_RESET;
            m_max   = MAX_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIXED_STEP: begin
                        if (i_cfg_data[STEP_W-1:0] < STEP_MIN)
                            m_step = STEP_MIN;
                        else if (i_cfg_data[STEP_W-1:0] > STEP_MAX)
                            m_step = STEP_MAX;
                        else
                            m_step = i_cfg_data[STEP_W-1:0];
                    end
                    CFG_MAX_STEPS: begin
                        m_max = (i_cfg_data[MAX_W-1:0] == '0) ? MAX_W'(1) : i_cfg_data[MAX_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (tick_results_q.size() == 0) begin
                    report_mismatch("unexpected result, steps", 64'(o_steps_taken), 64'd0);
                end else begin
                    want = tick_results_q.pop_front();
                    if (o_steps_taken !== want.steps)
                        report_mismatch("steps_taken", 64'(o_steps_taken), 64'(want.steps));
                    if (o_step_length !== want.step_len)
                        report_mismatch("step_length", 64'(o_step_length), 64'(want.step_len));
                    if (o_blend_alpha !== want.alpha)
                        report_mismatch("blend_alpha", 64'(o_blend_alpha), 64'(want.alpha));
                    if (o_total_time !== want.total)
                        report_mismatch("total_time", 64'(o_total_time), 64'(want.total));
                    if (o_tick_count !== want.ticks)
                        report_mismatch("tick_count", 64'(o_tick_count), 64'(want.ticks));
                    if (o_time_dropped !== want.dropped)
                        report_mismatch("time_dropped", 64'(o_time_dropped),
                                        64'(want.dropped));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predict_frame(i_action, i_frame_delta, want);
                row = frame_rows_q.pop_front();
                if (row.pinned)
                    want = row.res;
                tick_results_q.push_back(want);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // result side stall patterns, with one long hold when asked
    initial begin : out_pacing
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 4);
                left = $urandom_range(32, 256);
            end
            left--;
            case (mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= 1'($urandom_range(0, 1));
                2: i_out_stall <= ($urandom_range(0, 7) == 0);
                3: i_out_stall <= ((left % 5) < 2);
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic offer_frame(input t_frame_row row);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        frame_rows_q.push_back(row);
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_action      <= row.action;
        i_frame_delta <= row.delta;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic close_and_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tick_results_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        t_frame_row        row;
        logic [CFG_W-1:0]  step_w;
        logic [CFG_W-1:0]  max_w;
        int                sel;
        int                k;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (frame_plan[n])
            offer_frame(frame_plan[n]);
        close_and_drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin step_w = '0;                      max_w = CFG_W'(255);        end
                1: begin step_w = '1;                      max_w = CFG_W'(21'h000100); end
                2: begin step_w = CFG_W'(STEP_MIN);        max_w = CFG_W'(1);          end
                3: begin step_w = CFG_W'(STEP_MAX);        max_w = '1;                 end
                4: begin
                    step_w = CFG_W'($urandom_range(STEP_MIN, STEP_MAX));
                    max_w  = CFG_W'($urandom_range(1, 8));
                end
                5: begin step_w = CFG_W'($urandom);        max_w = CFG_W'($urandom);   end
                6: begin step_w = CFG_W'(STEP_MIN) - 1'b1; max_w = CFG_W'(MAX_RESET);  end
                default: begin
                    step_w = CFG_W'($urandom_range(STEP_MIN, STEP_MAX));
                    max_w  = CFG_W'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_FIXED_STEP, step_w);
            write_reg(CFG_MAX_STEPS, max_w);

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == 40)
                    hold_req = 1'b1;
                row        = '0;
                row.action = ACT_ADVANCE;
                sel        = $urandom_range(0, 99);
                if (sel < 3) begin
                    row.action = ACT_CLEAR;
                    row.delta  = DELTA_W'($urandom);
                end else if (sel < 8) begin
                    row.delta = {1'b1, 24'($urandom)};
                end else if (sel < 14) begin
                    row.delta = DELTA_W'($urandom_range(4194305, 16777215));
                end else if (sel < 20) begin
                    row.delta = DELTA_W'($urandom);
                end else if (sel < 26) begin
                    row.delta = DELTA_W'($urandom_range(0, 64));
                end else if (sel < 45) begin
                    // near whole multiples of the step
                    k = $urandom_range(1, 4);
                    row.delta = DELTA_W'(k * int'(m_step) - 1 + $urandom_range(0, 2));
                end else if (sel < 75) begin
                    row.delta = DELTA_W'($urandom_range(0, 2 * int'(m_step)));
                end else begin
                    row.delta = DELTA_W'($urandom_range(0, 4194304));
                end
                offer_frame(row);
            end
            close_and_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && tick_results_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
